>>> rtl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared widths, codes, payload structs and control types for the
// path corridor fix-up block.
// ----------------------------------------------------------------------------
package pcf_pkg;

	// storage sizes
	localparam int CORRIDOR_DEPTH = 256;
	localparam int VISITED_DEPTH  = 16;

	localparam int ADDR_W = $clog2(CORRIDOR_DEPTH);
	localparam int CNT_W  = $clog2(CORRIDOR_DEPTH + 1);
	localparam int VIDX_W = $clog2(VISITED_DEPTH);
	localparam int VCNT_W = $clog2(VISITED_DEPTH + 1);

	// fixed field widths
	localparam int REF_W    = 32;
	localparam int IDX_W    = 8;
	localparam int LEN_W    = 9;
	localparam int MAXP_W   = 9;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	localparam int MAX_PATH_RESET = 256;

	// width for the fix-up length arithmetic
	localparam int CALC_A = (CNT_W > VCNT_W) ? CNT_W : VCNT_W;
	localparam int CALC_W = ((CALC_A > MAXP_W) ? CALC_A : MAXP_W) + 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND_PATH = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND_VIS  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIXUP       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ        = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [REF_W-1:0] poly_ref;
		logic [IDX_W-1:0] index;
	} pcf_in_t;

	typedef struct packed {
		logic [REF_W-1:0]    poly_ref_out;
		logic [LEN_W-1:0]    path_length;
		logic                matched;
		logic [STATUS_W-1:0] status;
	} pcf_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_CALC,
		ST_MOVE,
		ST_VIS,
		ST_FINISH
	} pcf_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic srch;
		logic calc;
		logic move;
		logic vis;
		logic out_load;
	} pcf_ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic op_fixup;
		logic fix_empty;
		logic hit;
		logic srch_last;
		logic move_done;
		logic vis_done;
	} pcf_stat_t;

endpackage

>>> rtl/pcf_ctrl.sv
// ----------------------------------------------------------------------------
// pcf_ctrl
// Sequencer for the corridor fix-up block: handshakes and phase control.
// ----------------------------------------------------------------------------
module pcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pcf_pkg::pcf_stat_t stat,
	output pcf_pkg::pcf_ctrl_t ctrl
);
	import pcf_pkg::*;

	pcf_state_t state_q;
	pcf_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.op_fixup && !stat.fix_empty)
					state_d = ST_SEARCH;
				else
					state_d = ST_FINISH;
			end
			ST_SEARCH: begin
				if (stat.hit)
					state_d = ST_CALC;
				else if (stat.srch_last)
					state_d = ST_FINISH;
			end
			ST_CALC: begin
				state_d = ST_MOVE;
			end
			ST_MOVE: begin
				if (stat.move_done)
					state_d = ST_VIS;
			end
			ST_VIS: begin
				if (stat.vis_done)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// phase commands
	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			ST_EXEC:   ctrl.exec = 1'b1;
			ST_SEARCH: ctrl.srch = 1'b1;
			ST_CALC:   ctrl.calc = 1'b1;
			ST_MOVE:   ctrl.move = 1'b1;
			ST_VIS:    ctrl.vis  = 1'b1;
			ST_FINISH: ctrl.out_load = slot_free;
			default: begin
				ctrl = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/pcf_datapath.sv
// ----------------------------------------------------------------------------
// pcf_datapath
// Corridor memory, visited list, counters, search compare and move logic.
// ----------------------------------------------------------------------------
module pcf_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pcf_pkg::pcf_in_t           in_data,
	input  logic                       cfg_we,
	input  logic [pcf_pkg::MAXP_W-1:0] cfg_data,
	input  pcf_pkg::pcf_ctrl_t         ctrl,
	output pcf_pkg::pcf_stat_t         stat,
	output pcf_pkg::pcf_out_t          out_data
);
	import pcf_pkg::*;

	// corridor memory, one write and one registered read port
	logic [REF_W-1:0] mem [CORRIDOR_DEPTH];
	logic [REF_W-1:0] rdata_q;
	logic             rd_en;
	logic [ADDR_W-1:0] raddr;
	logic             mem_we;
	logic [ADDR_W-1:0] waddr;
	logic [REF_W-1:0] wdata;

	logic [REF_W-1:0] visited_q [VISITED_DEPTH];

	logic [CMD_W-1:0]  cmd_q;
	logic [REF_W-1:0]  ref_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  ccount_q;
	logic [VCNT_W-1:0] vcount_q;
	logic [MAXP_W-1:0] max_path_q;

	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] dst_q;
	logic [CNT_W-1:0]  left_q;
	logic              pend_s1;
	logic              desc_q;
	logic [ADDR_W-1:0] hit_path_q;
	logic [VIDX_W-1:0] hit_vis_q;
	logic [CNT_W-1:0]  req_q;
	logic [CNT_W-1:0]  size_q;
	logic [CNT_W-1:0]  vi_q;

	logic                matched_q;
	logic                rd_sel_q;
	logic [STATUS_W-1:0] status_q;
	pcf_out_t            out_q;

	logic [VISITED_DEPTH-1:0] match_vec;
	logic                     hit;
	logic [VIDX_W-1:0]        hit_idx;
	logic                     path_room;
	logic                     vis_room;
	logic                     idx_ok;
	logic                     fix_empty;
	logic                     vis_done;
	logic [VIDX_W-1:0]        vis_sel;

	logic [CALC_W-1:0] lim_c;
	logic [CALC_W-1:0] av_c;
	logic [CALC_W-1:0] req_c;
	logic [CALC_W-1:0] orig_c;
	logic [CALC_W-1:0] size0_c;
	logic [CALC_W-1:0] size_c;
	logic [CALC_W-1:0] src_c;
	logic [CALC_W-1:0] dst_c;
	logic              desc_c;

	assign path_room = ccount_q < CNT_W'(CORRIDOR_DEPTH);
	assign vis_room  = vcount_q < VCNT_W'(VISITED_DEPTH);
	assign idx_ok    = CALC_W'(idx_q) < CALC_W'(ccount_q);
	assign fix_empty = (ccount_q == '0) || (vcount_q == '0);
	assign vis_done  = vi_q == req_q;
	assign vis_sel   = VIDX_W'(vcount_q - VCNT_W'(1) - VCNT_W'(vi_q));

	// compare the fetched corridor id against every live visited entry
	always_comb begin
		for (int j = 0; j < VISITED_DEPTH; j++)
			match_vec[j] = (VCNT_W'(j) < vcount_q) && (visited_q[j] == rdata_q);
	end

	// earliest visited position wins
	always_comb begin
		hit_idx = '0;
		for (int j = VISITED_DEPTH - 1; j >= 0; j--)
			if (match_vec[j])
				hit_idx = VIDX_W'(j);
	end

	assign hit = |match_vec;

	// fix-up lengths
	always_comb begin
		lim_c = (CALC_W'(max_path_q) > CALC_W'(CORRIDOR_DEPTH)) ?
			CALC_W'(CORRIDOR_DEPTH) : CALC_W'(max_path_q);
		av_c    = CALC_W'(vcount_q) - CALC_W'(hit_vis_q);
		req_c   = (av_c > lim_c) ? lim_c : av_c;
		orig_c  = CALC_W'(hit_path_q) + CALC_W'(1);
		size0_c = CALC_W'(ccount_q) - orig_c;
		size_c  = ((req_c + size0_c) > lim_c) ? (lim_c - req_c) : size0_c;
		desc_c  = req_c > orig_c;
		// shifting up walks from the top end so no source is overwritten early
		src_c   = desc_c ? (orig_c + size_c - CALC_W'(1)) : orig_c;
		dst_c   = desc_c ? (req_c + size_c - CALC_W'(1)) : req_c;
	end

	// read port address
	always_comb begin
		raddr = ptr_q;
		rd_en = 1'b0;
		if (ctrl.exec) begin
			rd_en = 1'b1;
			if (cmd_q == CMD_FIXUP)
				raddr = ADDR_W'(ccount_q - CNT_W'(1));
			else
				raddr = ADDR_W'(idx_q);
		end else if (ctrl.srch) begin
			rd_en = 1'b1;
			raddr = ptr_q - ADDR_W'(1);
		end else if (ctrl.move) begin
			rd_en = 1'b1;
			raddr = ptr_q;
		end
	end

	// write port
	always_comb begin
		mem_we = 1'b0;
		waddr  = dst_q;
		wdata  = rdata_q;
		if (ctrl.exec && (cmd_q == CMD_APPEND_PATH) && path_room) begin
			mem_we = 1'b1;
			waddr  = ADDR_W'(ccount_q);
			wdata  = ref_q;
		end else if (ctrl.move && pend_s1) begin
			mem_we = 1'b1;
			waddr  = dst_q;
			wdata  = rdata_q;
		end else if (ctrl.vis && !vis_done) begin
			mem_we = 1'b1;
			waddr  = ADDR_W'(vi_q);
			wdata  = visited_q[vis_sel];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (rd_en)
			rdata_q <= mem[raddr];
	end

	// counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccount_q   <= '0;
			vcount_q   <= '0;
			max_path_q <= MAXP_W'(MAX_PATH_RESET);
			pend_s1    <= 1'b0;
		end else begin
			if (cfg_we)
				max_path_q <= cfg_data;
			pend_s1 <= ctrl.move && (left_q != '0);
			if (ctrl.exec) begin
				case (cmd_q)
					CMD_APPEND_PATH: begin
						if (path_room)
							ccount_q <= ccount_q + CNT_W'(1);
					end
					CMD_APPEND_VIS: begin
						if (vis_room)
							vcount_q <= vcount_q + VCNT_W'(1);
					end
					CMD_FIXUP: begin
						if (fix_empty)
							vcount_q <= '0;
					end
					CMD_CLEAR: begin
						ccount_q <= '0;
						vcount_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (ctrl.srch && !hit && (ptr_q == '0))
				vcount_q <= '0;
			if (ctrl.vis && vis_done) begin
				ccount_q <= CNT_W'(req_q + size_q);
				vcount_q <= '0;
			end
		end
	end

	// item payload and work registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q     <= in_data.command;
			ref_q     <= in_data.poly_ref;
			idx_q     <= in_data.index;
			status_q  <= STATUS_OK;
			matched_q <= 1'b0;
			rd_sel_q  <= 1'b0;
		end
		if (ctrl.exec) begin
			case (cmd_q)
				CMD_APPEND_PATH: begin
					if (!path_room)
						status_q <= STATUS_FULL;
				end
				CMD_APPEND_VIS: begin
					if (vis_room)
						visited_q[VIDX_W'(vcount_q)] <= ref_q;
					else
						status_q <= STATUS_FULL;
				end
				CMD_FIXUP: begin
					ptr_q <= ADDR_W'(ccount_q - CNT_W'(1));
				end
				CMD_READ: begin
					if (idx_ok)
						rd_sel_q <= 1'b1;
					else
						status_q <= STATUS_RANGE;
				end
				default: begin
				end
			endcase
		end
		if (ctrl.srch) begin
			if (hit) begin
				hit_path_q <= ptr_q;
				hit_vis_q  <= hit_idx;
			end else begin
				ptr_q <= ptr_q - ADDR_W'(1);
			end
		end
		if (ctrl.calc) begin
			req_q  <= CNT_W'(req_c);
			size_q <= CNT_W'(size_c);
			left_q <= CNT_W'(size_c);
			desc_q <= desc_c;
			ptr_q  <= ADDR_W'(src_c);
			dst_q  <= ADDR_W'(dst_c);
			vi_q   <= '0;
		end
		if (ctrl.move) begin
			if (left_q != '0) begin
				ptr_q  <= desc_q ? (ptr_q - ADDR_W'(1)) : (ptr_q + ADDR_W'(1));
				left_q <= left_q - CNT_W'(1);
			end
			if (pend_s1)
				dst_q <= desc_q ? (dst_q - ADDR_W'(1)) : (dst_q + ADDR_W'(1));
		end
		if (ctrl.vis) begin
			if (vis_done)
				matched_q <= 1'b1;
			else
				vi_q <= vi_q + CNT_W'(1);
		end
		if (ctrl.out_load) begin
			out_q.poly_ref_out <= rd_sel_q ? rdata_q : '0;
			out_q.path_length  <= LEN_W'(ccount_q);
			out_q.matched      <= matched_q;
			out_q.status       <= status_q;
		end
	end

	always_comb begin
		stat.op_fixup  = cmd_q == CMD_FIXUP;
		stat.fix_empty = fix_empty;
		stat.hit       = hit;
		stat.srch_last = ptr_q == '0;
		stat.move_done = (left_q == '0) && !pend_s1;
		stat.vis_done  = vis_done;
	end

	assign out_data = out_q;

endmodule

>>> rtl/path_corridor_fixup.sv
// ----------------------------------------------------------------------------
// path_corridor_fixup
// Polygon corridor store with visited-list fix-up, read-back and clear.
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_data): one command item per handshake:
//   append path id, append visited id, fix up, read by index, clear
//   out channel (out_valid/out_ready/out_data): exactly one result item per
//   command, in order, holding the read id, new length, match flag, status
//   cfg_we/cfg_data write max_path, only while no item is in flight
// timing
//   appends, read, clear and the undefined codes: execute, then the result is
//   loaded in the finish phase; the next item is taken the cycle after the
//   result is loaded, so no item is taken before the last one is through
//   fix up: S corridor entries searched from the end, M tail entries moved,
//   R visited ids written back in reverse; the single read and single write
//   port of the corridor memory set the pace, one entry per cycle in each
//   phase
// reset
//   both lists empty, max_path back to 256, no result pending
// stall
//   a result waits in the output register while the next item is taken;
//   the block holds in its last phase until that register frees up
// ----------------------------------------------------------------------------
module path_corridor_fixup (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  pcf_pkg::pcf_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output pcf_pkg::pcf_out_t          out_data,
	input  logic                       cfg_we,
	input  logic [pcf_pkg::MAXP_W-1:0] cfg_data
);
	import pcf_pkg::*;

	// phase commands from the sequencer, status flags back from the datapath
	pcf_ctrl_t ctrl;
	pcf_stat_t stat;

	// sequencer: idle, execute, search, length calc, tail move, write-back,
	// result hand-off
	pcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// corridor memory, visited list, counters and the output register
	pcf_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

>>> rtl/pcf_checker.sv
// ----------------------------------------------------------------------------
// pcf_port_checks
// Port-level checks for the path corridor fix-up block, bound to the top.
// ----------------------------------------------------------------------------
module pcf_port_checks (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input pcf_pkg::pcf_out_t out_data
);
	import pcf_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one item at a time: an accept closes the input for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in work");

	// a refused read returns zero
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STATUS_RANGE) |-> out_data.poly_ref_out == '0)
		else $error("refused read returned data");

	// a matching fix-up is never refused and never carries read data
	a_match_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.matched |->
			(out_data.status == STATUS_OK) && (out_data.poly_ref_out == '0))
		else $error("matched result with status or data");

endmodule

bind path_corridor_fixup pcf_port_checks u_pcf_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
